/* rtl/core/ble_pkg.sv */
// Shared types and constants for the battery level estimator.
// Holds widths, reciprocal constants, the configuration layout and a stage struct.
// No dependencies.
package ble_pkg;

  // batch size, a power of two from 1 to 64
  localparam int unsigned SAMPLES_PER_BATCH = 16;
  localparam int unsigned BATCH_LOG2 = $clog2(SAMPLES_PER_BATCH);
  localparam int unsigned CNT_W = (BATCH_LOG2 > 0) ? BATCH_LOG2 : 1;

  // field widths
  localparam int unsigned ADC_W = 12;
  localparam int unsigned MV_W = 15;
  localparam int unsigned Q8_W = 23;
  localparam int unsigned PCT_W = 7;
  localparam int unsigned SUM_W = ADC_W + BATCH_LOG2;
  localparam int unsigned CFG_IDX_W = 3;

  // mean * 18000 compared against threshold * 4095
  localparam int unsigned SCALED_W = 27;
  localparam int unsigned MV_FULL_SCALE = 18000;
  localparam int unsigned ADC_FULL_SCALE = 4095;

  // v = mean*102400/91 = 1125*mean + floor(25*mean/91)
  localparam int unsigned V_INT_MUL = 1125;
  localparam int unsigned V_FRAC_MUL = 4609150;   // 25 * ceil(2^24 / 91)
  localparam int unsigned V_FRAC_SHIFT = 24;
  localparam int unsigned V_FRAC_W = ADC_W + 23;

  // filter update, divide by five over a 26-bit dividend
  localparam int unsigned FSUM_W = Q8_W + 3;
  localparam int unsigned DIV5_MUL = 107374183;   // ceil(2^29 / 5)
  localparam int unsigned DIV5_SHIFT = 29;
  localparam int unsigned FPROD_W = FSUM_W + 27;

  // percent slopes
  localparam int unsigned LOW_SHIFT = 9;          // 7680 = 512 * 15
  localparam int unsigned DIV15_MUL = 17477;      // ceil(2^18 / 15)
  localparam int unsigned HIGH_SHIFT = 10;        // 5120 = 1024 * 5
  localparam int unsigned DIV5S_MUL = 52429;      // ceil(2^18 / 5)
  localparam int unsigned PCT_RECIP_SHIFT = 18;
  localparam int unsigned PCT_MAX = 100;
  localparam int unsigned KNEE_PCT = 10;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_USB_THRESHOLD = 3'd0,
    REG_MIN_VALID     = 3'd1,
    REG_MAX_VALID     = 3'd2,
    REG_EMPTY         = 3'd3,
    REG_KNEE          = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [MV_W-1:0] usb_threshold_mv;
    logic [MV_W-1:0] min_valid_mv;
    logic [MV_W-1:0] max_valid_mv;
    logic [MV_W-1:0] empty_mv;
    logic [MV_W-1:0] knee_mv;
  } cfg_t;

  // per-batch voltage decisions
  typedef struct packed {
    logic            usb;
    logic            in_window;
    logic [Q8_W-1:0] volt_q8;
  } volt_t;

endpackage

/* rtl/core/ble_volt.sv */
// Batch mean to Q.8 millivolts, USB flag and valid window check.
// Depends on ble_pkg.
module ble_volt
  import ble_pkg::*;
(
  input  logic [ADC_W-1:0] mean,
  input  cfg_t             cfg,
  output volt_t            volt
);

  logic [SCALED_W-1:0] scaled;
  logic [SCALED_W-1:0] usb_lim;
  logic [SCALED_W-1:0] min_lim;
  logic [SCALED_W-1:0] max_lim;
  logic [V_FRAC_W-1:0] frac_prod;
  logic [Q8_W-1:0]     int_part;

  // exact compares against threshold * 4095
  assign scaled  = SCALED_W'(mean) * SCALED_W'(MV_FULL_SCALE);
  assign usb_lim = SCALED_W'(cfg.usb_threshold_mv) * SCALED_W'(ADC_FULL_SCALE);
  assign min_lim = SCALED_W'(cfg.min_valid_mv) * SCALED_W'(ADC_FULL_SCALE);
  assign max_lim = SCALED_W'(cfg.max_valid_mv) * SCALED_W'(ADC_FULL_SCALE);

  // floor(mean * 18000 * 256 / 4095)
  assign frac_prod = V_FRAC_W'(mean) * V_FRAC_W'(V_FRAC_MUL);
  assign int_part  = Q8_W'(mean) * Q8_W'(V_INT_MUL);

  assign volt.usb       = (scaled > usb_lim);
  assign volt.in_window = (scaled > min_lim) && (scaled < max_lim);
  assign volt.volt_q8   = int_part + Q8_W'(frac_prod >> V_FRAC_SHIFT);

endmodule

/* rtl/core/ble_pct.sv */
// Charge percent from the filtered Q.8 millivolt value, two slopes and a clamp.
// Depends on ble_pkg.
module ble_pct
  import ble_pkg::*;
(
  input  logic [Q8_W-1:0]  filt,
  input  cfg_t             cfg,
  output logic [PCT_W-1:0] percent
);

  logic [Q8_W-1:0]   e_q8;
  logic [Q8_W-1:0]   k_q8;
  logic [Q8_W-1:0]   low_diff;
  logic [Q8_W-1:0]   high_diff;
  logic [Q8_W+1:0]   high_x3;
  logic [31:0]       low_prod;
  logic [31:0]       high_prod;
  logic [10:0]       low_q;
  logic [12:0]       high_q;

  assign e_q8 = {cfg.empty_mv, 8'd0};
  assign k_q8 = {cfg.knee_mv, 8'd0};

  // low region: 30 mV per percent
  assign low_diff = filt - e_q8;
  assign low_prod = 32'(low_diff[Q8_W-1:LOW_SHIFT]) * 32'(DIV15_MUL);
  assign low_q    = 11'(low_prod >> PCT_RECIP_SHIFT);

  // main region: 0.15 percent per mV
  assign high_diff = filt - k_q8;
  assign high_x3   = (Q8_W+2)'(high_diff) * (Q8_W+2)'(3);
  assign high_prod = 32'(high_x3[Q8_W+1:HIGH_SHIFT]) * 32'(DIV5S_MUL);
  assign high_q    = 13'(high_prod >> PCT_RECIP_SHIFT);

  // region select and saturation
  always_comb begin
    if (filt <= e_q8) begin
      percent = '0;
    end else if (filt < k_q8) begin
      percent = (low_q > 11'(PCT_MAX)) ? PCT_W'(PCT_MAX) : PCT_W'(low_q);
    end else begin
      percent = (high_q >= 13'(PCT_MAX - KNEE_PCT)) ? PCT_W'(PCT_MAX)
                                                    : PCT_W'(high_q + 13'(KNEE_PCT));
    end
  end

endmodule

/* rtl/core/battery_level_estimator_core.sv */
// Battery fuel gauge: batch averaging, voltage conversion, EMA filter, percent.
// Depends on ble_pkg, ble_volt and ble_pct.
//
// Usage:
//   Input channel (in_valid/in_stall/adc_sample) takes one raw ADC sample per
//   transaction, one per cycle unless in_stall is high. Every SAMPLES_PER_BATCH
//   samples close a batch and produce one output transaction (usb_powered,
//   estimate_valid, battery_percent, filtered_mv); other samples produce none.
//   Timing: the result of a batch is held in the mean register, loaded at the
//   edge that accepts the closing sample, then in the voltage, filter and
//   output registers in turn.
//   Throughput: one sample per cycle while in_stall is low; the four stages
//   advance independently, so a waiting result does not block input until all
//   stages behind the output register are occupied.
//   Configuration: cfg_write/cfg_index/cfg_data write one register per cycle,
//   unknown indexes ignored; write only while the block is idle (not enforced).
//   Reset (rst, synchronous) restores register defaults, clears the batch,
//   the filter, the seeded flag and the held percent.
//   While out_stall is high the output transaction holds unchanged.
module battery_level_estimator_core
  import ble_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MV_W-1:0]      cfg_data,
  // sample input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ADC_W-1:0]     adc_sample,
  // result output
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 usb_powered,
  output logic                 estimate_valid,
  output logic [PCT_W-1:0]     battery_percent,
  output logic [MV_W-1:0]      filtered_mv
);

  cfg_t cfg;

  logic [CNT_W-1:0] count;
  logic [SUM_W-1:0] sum;
  logic             a_valid;
  logic [ADC_W-1:0] a_mean;
  logic             b_valid;
  logic             b_usb;
  logic             b_upd;
  logic [Q8_W-1:0]  b_volt;
  logic             c_valid;
  logic             c_usb;
  logic             c_upd;
  logic [Q8_W-1:0]  filter;
  logic             seeded;

  logic             rdy_a, rdy_b, rdy_c, rdy_d;
  logic             in_accept;
  logic             last;
  logic [SUM_W-1:0] sum_next;
  volt_t            volt;
  logic [FSUM_W-1:0]  fsum;
  logic [FPROD_W-1:0] fprod;
  logic [Q8_W-1:0]    filter_avg;
  logic [PCT_W-1:0]   pct_now;

  // stage flow control
  assign rdy_d     = !out_valid || !out_stall;
  assign rdy_c     = !c_valid || rdy_d;
  assign rdy_b     = !b_valid || rdy_c;
  assign rdy_a     = !a_valid || rdy_b;
  assign in_stall  = !rdy_a;
  assign in_accept = in_valid && rdy_a;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.usb_threshold_mv <= MV_W'(4400);
      cfg.min_valid_mv     <= MV_W'(3000);
      cfg.max_valid_mv     <= MV_W'(4500);
      cfg.empty_mv         <= MV_W'(3300);
      cfg.knee_mv          <= MV_W'(3600);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_USB_THRESHOLD: cfg.usb_threshold_mv <= cfg_data;
        REG_MIN_VALID:     cfg.min_valid_mv     <= cfg_data;
        REG_MAX_VALID:     cfg.max_valid_mv     <= cfg_data;
        REG_EMPTY:         cfg.empty_mv         <= cfg_data;
        REG_KNEE:          cfg.knee_mv          <= cfg_data;
        default: ;
      endcase
    end
  end

  // batch accumulation and mean register
  assign last     = (count == CNT_W'(SAMPLES_PER_BATCH - 1));
  assign sum_next = sum + SUM_W'(adc_sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      sum     <= '0;
      a_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        if (last) begin
          count <= '0;
          sum   <= '0;
        end else begin
          count <= count + CNT_W'(1);
          sum   <= sum_next;
        end
      end
      if (rdy_a) begin
        a_valid <= in_accept && last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && last && rdy_a) begin
      a_mean <= ADC_W'(sum_next >> BATCH_LOG2);
    end
  end

  // voltage conversion stage
  ble_volt u_volt (
    .mean (a_mean),
    .cfg  (cfg),
    .volt (volt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (rdy_b) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b && a_valid) begin
      b_usb  <= volt.usb;
      b_upd  <= volt.in_window && !volt.usb;
      b_volt <= volt.volt_q8;
    end
  end

  // filter update: (4*f + v) / 5 by reciprocal
  assign fsum       = (FSUM_W'(filter) << 2) + FSUM_W'(b_volt);
  assign fprod      = FPROD_W'(fsum) * FPROD_W'(DIV5_MUL);
  assign filter_avg = Q8_W'(fprod >> DIV5_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      filter  <= '0;
      seeded  <= 1'b0;
    end else if (rdy_c) begin
      c_valid <= b_valid;
      if (b_valid && b_upd) begin
        filter <= seeded ? filter_avg : b_volt;
        seeded <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c && b_valid) begin
      c_usb <= b_usb;
      c_upd <= b_upd;
    end
  end

  // percent and output register
  ble_pct u_pct (
    .filt    (filter),
    .cfg     (cfg),
    .percent (pct_now)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      battery_percent <= '0;
    end else if (rdy_d) begin
      out_valid <= c_valid;
      if (c_valid && c_upd) begin
        battery_percent <= pct_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_d && c_valid) begin
      usb_powered    <= c_usb;
      estimate_valid <= seeded;
      filtered_mv    <= filter[Q8_W-1:8];
    end
  end

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for battery_level_estimator_core: batch averaging, USB and window
// decisions, filter update and percent mapping, predicted per accepted sample.
// Depends on ble_pkg and the battery_level_estimator_core RTL.
module tb_top;
  import ble_pkg::*;

  localparam int RESET_CYCLES   = 12;
  localparam int LATENCY_CYCLES = 4;
  localparam int SETTLE_CYCLES  = 2 * LATENCY_CYCLES;
  localparam int LONG_HOLD      = 300;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int ADC_MAX        = (1 << ADC_W) - 1;
  localparam int MV_RANGE_TOP   = 18000;
  localparam longint unsigned LOW_SLOPE_Q8   = 7680;  // 30 mV per percent in Q.8
  localparam longint unsigned HIGH_SLOPE_DEN = 5120;  // 0.15 percent per mV
  localparam logic [MV_W-1:0] MV_REG_MAX = '1;

  // one result transaction
  typedef struct packed {
    logic             usb;
    logic             seeded;
    logic [PCT_W-1:0] pct;
    logic [MV_W-1:0]  mv;
  } gauge_reading_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MV_W-1:0]      cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [ADC_W-1:0]     adc_sample = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 usb_powered;
  logic                 estimate_valid;
  logic [PCT_W-1:0]     battery_percent;
  logic [MV_W-1:0]      filtered_mv;

  battery_level_estimator_core dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .adc_sample      (adc_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .usb_powered     (usb_powered),
    .estimate_valid  (estimate_valid),
    .battery_percent (battery_percent),
    .filtered_mv     (filtered_mv)
  );

  // clock, period 4
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // gauge state mirrored by the predictor
  logic [MV_W-1:0]  thr_usb_mv   = 15'd4400;
  logic [MV_W-1:0]  win_lo_mv    = 15'd3000;
  logic [MV_W-1:0]  win_hi_mv    = 15'd4500;
  logic [MV_W-1:0]  empty_set_mv = 15'd3300;
  logic [MV_W-1:0]  knee_set_mv  = 15'd3600;
  longint unsigned  acc_sum      = 0;
  int               acc_count    = 0;
  longint unsigned  filt_q8      = 0;
  logic             est_seeded   = 1'b0;
  logic [PCT_W-1:0] pct_held     = '0;

  gauge_reading_t expected_readings[$];
  gauge_reading_t want;
  int             mismatches = 0;

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_toggle    = 1'b0;
  logic hold_seen      = 1'b0;
  int   hold_left      = 0;

  // percent from the filter in Q.8 mV
  function automatic logic [PCT_W-1:0] percent_from_filter(longint unsigned f);
    longint unsigned e;
    longint unsigned k;
    longint unsigned p;
    e = 64'(empty_set_mv) << 8;
    k = 64'(knee_set_mv) << 8;
    if (f <= e) return '0;
    if (f < k) p = (f - e) / LOW_SLOPE_Q8;
    else p = KNEE_PCT + ((f - k) * 3) / HIGH_SLOPE_DEN;
    if (p > PCT_MAX) p = PCT_MAX;
    return p[PCT_W-1:0];
  endfunction

  // accumulate one sample, and on a closed batch queue the expected reading
  function automatic void take_sample(logic [ADC_W-1:0] s);
    longint unsigned mean_adc;
    longint unsigned scaled;
    longint unsigned volt_q8;
    logic            usb_now;
    gauge_reading_t  r;
    acc_sum += s;
    acc_count++;
    if (acc_count < SAMPLES_PER_BATCH) return;
    mean_adc = acc_sum / SAMPLES_PER_BATCH;
    if (mean_adc > ADC_MAX) mean_adc = ADC_MAX;
    acc_sum = 0;
    acc_count = 0;
    scaled = mean_adc * MV_FULL_SCALE;
    volt_q8 = (scaled * 256) / ADC_FULL_SCALE;
    usb_now = scaled > 64'(thr_usb_mv) * ADC_FULL_SCALE;
    if (!usb_now && scaled > 64'(win_lo_mv) * ADC_FULL_SCALE &&
        scaled < 64'(win_hi_mv) * ADC_FULL_SCALE) begin
      if (!est_seeded) begin
        filt_q8 = volt_q8;
        est_seeded = 1'b1;
      end else begin
        filt_q8 = (4 * filt_q8 + volt_q8) / 5;
      end
      filt_q8 &= (64'd1 << Q8_W) - 1;
      pct_held = percent_from_filter(filt_q8);
    end
    r.usb = usb_now;
    r.seeded = est_seeded;
    r.pct = pct_held;
    r.mv = filt_q8[Q8_W-1:8];
    expected_readings.push_back(r);
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [MV_W-1:0] val);
    case (idx)
      REG_USB_THRESHOLD: thr_usb_mv = val;
      REG_MIN_VALID:     win_lo_mv = val;
      REG_MAX_VALID:     win_hi_mv = val;
      REG_EMPTY:         empty_set_mv = val;
      REG_KNEE:          knee_set_mv = val;
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] got);
    if (got !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got);
      mismatches++;
    end
  endfunction

  // predictor update and result checking at every rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write) apply_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) take_sample(adc_sample);
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          $error("result transaction with no reading expected");
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          check_field("usb_powered", want.usb, usb_powered);
          check_field("estimate_valid", want.seeded, estimate_valid);
          check_field("battery_percent", want.pct, battery_percent);
          check_field("filtered_mv", want.mv, filtered_mv);
        end
      end
    end
  end

  // receiver: random stall, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // run limit
  initial begin
    #(TIMEOUT_CYCLES * 4);
    $display("TB_ERROR");
    $finish;
  end

  // send one sample transaction; entered and left at a falling edge
  task automatic send_sample(input logic [ADC_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    adc_sample <= s;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // one batch scattered around a base value
  task automatic send_batch(input int base, input int spread);
    int s;
    for (int i = 0; i < SAMPLES_PER_BATCH; i++) begin
      s = base + int'($urandom_range(2 * spread)) - spread;
      if (s < 0) s = 0;
      if (s > ADC_MAX) s = ADC_MAX;
      send_sample(ADC_W'(s));
    end
  endtask

  // one batch alternating two values, exercises mean truncation
  task automatic send_alternating(input int a, input int b);
    for (int i = 0; i < SAMPLES_PER_BATCH; i++) send_sample(ADC_W'((i % 2) ? b : a));
  endtask

  // drop valid, wait for every expected reading, then let the pipeline go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MV_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    send_idle_pct = sender_pct;
    recv_stall_pct = receiver_pct;
  endtask

  function automatic logic [MV_W-1:0] pick_mv(input int lo, input int hi);
    case ($urandom_range(31))
      0: return '0;
      1: return MV_W'(MV_RANGE_TOP);
      2: return MV_REG_MAX;
      default: return MV_W'($urandom_range(hi, lo));
    endcase
  endfunction

  // reset settings: zero mean, full scale, seeding, update, usb hold
  task automatic test_reset_defaults();
    set_idling(0, 0);
    send_batch(0, 0);
    send_batch(ADC_MAX, 0);
    send_alternating(841, 842);
    send_batch(700, 0);
    send_alternating(0, ADC_MAX);
  endtask

  // usb and window thresholds are strict, compared exactly
  task automatic test_exact_thresholds();
    settle();
    write_reg(REG_USB_THRESHOLD, 15'd400);
    write_reg(REG_MIN_VALID, '0);
    write_reg(REG_MAX_VALID, MV_REG_MAX);
    write_reg(REG_EMPTY, '0);
    write_reg(REG_KNEE, '0);
    send_batch(91, 0);   // exactly at the usb threshold
    send_batch(92, 0);
    settle();
    write_reg(REG_USB_THRESHOLD, MV_REG_MAX);
    write_reg(REG_MIN_VALID, 15'd400);
    send_batch(91, 0);   // exactly at the lower window edge
    send_batch(92, 0);
  endtask

  // saturation in both slope regions and reversed empty/knee
  task automatic test_percent_regions();
    settle();
    write_reg(REG_MIN_VALID, '0);
    send_batch(ADC_MAX, 0);
    send_batch(ADC_MAX, 0);
    settle();
    write_reg(REG_KNEE, MV_W'(MV_RANGE_TOP));
    send_batch(ADC_MAX, 0);
    settle();
    write_reg(REG_EMPTY, MV_W'(MV_RANGE_TOP));
    write_reg(REG_KNEE, '0);
    send_batch(4000, 0);
    settle();
    write_reg(REG_EMPTY, 15'd3300);
    write_reg(REG_KNEE, 15'd3600);
    send_batch(800, 0);
  endtask

  // closed window holds the estimate; unknown indexes change nothing
  task automatic test_held_and_unused();
    settle();
    write_reg(REG_MAX_VALID, '0);
    send_batch(841, 0);
    settle();
    write_reg(REG_MAX_VALID, 15'd4500);
    for (int i = REG_KNEE + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), MV_W'($urandom_range(MV_REG_MAX)));
    send_batch(841, 0);
  endtask

  // long receiver hold-off with the sender still offering, then drain pauses
  task automatic test_backpressure();
    settle();
    set_idling(0, 0);
    hold_toggle <= ~hold_toggle;
    for (int b = 0; b < 10; b++) send_batch(820, 20);
    settle();
    send_batch(2048, 2048);
    settle();
    send_batch(760, 4);
  endtask

  // random settings and well-formed batches under every idling mode
  task automatic test_random_traffic();
    int kind;
    int lo_adc;
    int hi_adc;
    int usb_adc;
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: set_idling(0, 0);
        1: set_idling(85, 0);
        2: set_idling(0, 85);
        default: set_idling(21, 21);
      endcase
      for (int phase = 0; phase < 2; phase++) begin
        settle();
        write_reg(REG_USB_THRESHOLD, pick_mv(4300, 5200));
        write_reg(REG_MIN_VALID, pick_mv(2500, 3800));
        write_reg(REG_MAX_VALID, pick_mv(3900, 4800));
        write_reg(REG_EMPTY, pick_mv(2800, 3700));
        write_reg(REG_KNEE, pick_mv(3000, 4100));
        for (int b = 0; b < 7; b++) begin
          kind = $urandom_range(99);
          lo_adc = int'(win_lo_mv) * ADC_FULL_SCALE / MV_FULL_SCALE + 1;
          hi_adc = int'(win_hi_mv) * ADC_FULL_SCALE / MV_FULL_SCALE;
          usb_adc = int'(thr_usb_mv) * ADC_FULL_SCALE / MV_FULL_SCALE + 1;
          if (hi_adc > ADC_MAX) hi_adc = ADC_MAX;
          if (kind < 65 && hi_adc > lo_adc)
            send_batch($urandom_range(hi_adc, lo_adc), $urandom_range(8));
          else if (kind < 80 && usb_adc < ADC_MAX)
            send_batch($urandom_range(ADC_MAX, usb_adc), $urandom_range(8));
          else
            send_batch(2048, 2048);
          // occasionally the sender waits for every reading
          if ($urandom_range(7) == 0) settle();
        end
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_exact_thresholds();
    test_percent_regions();
    test_held_and_unused();
    test_backpressure();
    test_random_traffic();
    settle();
    repeat (4 * LATENCY_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* battery_level_estimator_core.f */
rtl/core/ble_pkg.sv
rtl/core/ble_volt.sv
rtl/core/ble_pct.sv
rtl/core/battery_level_estimator_core.sv
tb/tb_top.sv
